// ===== design/vws_pkg.sv =====
// shared types and constants for the vibration window statistics block
`default_nettype none

package vws_pkg;

  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned LEN_BITS   = 16;
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned INDEX_BITS = 4;
  localparam int unsigned FLAG_BITS  = 3;

  localparam logic [LEN_BITS-1:0] WINDOW_LENGTH_RESET = 16'd1024;

  // request kinds
  localparam logic [1:0] REQ_BEGIN  = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_END    = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FAULT   = 2'd2;

  // statistic word indexes
  localparam logic [INDEX_BITS-1:0] IDX_SUM_X  = 4'd0;
  localparam logic [INDEX_BITS-1:0] IDX_SUM_Y  = 4'd1;
  localparam logic [INDEX_BITS-1:0] IDX_SUM_Z  = 4'd2;
  localparam logic [INDEX_BITS-1:0] IDX_SUM_V  = 4'd3;
  localparam logic [INDEX_BITS-1:0] IDX_PEAK_X = 4'd4;
  localparam logic [INDEX_BITS-1:0] IDX_PEAK_Y = 4'd5;
  localparam logic [INDEX_BITS-1:0] IDX_PEAK_Z = 4'd6;
  localparam logic [INDEX_BITS-1:0] IDX_PEAK_V = 4'd7;
  localparam logic [INDEX_BITS-1:0] IDX_ACQ    = 4'd8;
  localparam logic [INDEX_BITS-1:0] IDX_VALID  = 4'd9;
  localparam logic [INDEX_BITS-1:0] IDX_START  = 4'd10;
  localparam logic [INDEX_BITS-1:0] IDX_END    = 4'd11;
  localparam logic [INDEX_BITS-1:0] IDX_FLAGS  = 4'd12;

  // sticky window flag bits
  localparam int unsigned FLAG_OVERFLOW   = 0;
  localparam int unsigned FLAG_SATURATION = 1;
  localparam int unsigned FLAG_SRC_ERROR  = 2;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           req;
    logic                 good;
    logic                 clipped;
    logic                 fault;
    logic [TIME_BITS-1:0] time_ms;
  } item_ctl_t;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           status;
    logic                 burst;
    logic [TIME_BITS-1:0] end_time;
  } ack_t;

  typedef struct packed {
    logic                  ready;
    logic [INDEX_BITS-1:0] sel;
  } emit_req_t;

endpackage

`default_nettype wire

// ===== design/vibration_window_statistics_core.sv =====
// top level of the vibration window statistics block
//
// input stream words carry begin, sample or end requests (kind in tuser) for one
// three-axis accelerometer window; output stream words carry statistic results.
// begin, sample and every rejected request give one word with index 0, value 0
// and tlast set; an end on an open window gives thirteen words: four sums of
// squares, four peaks, acquired and valid counts, start and end time, and flags.
// the config channel writes the window length; it is always ready and is
// latched by the next begin. write it only while the block is idle.
// a word passes the input register, the squaring register and the output register
// on its way from its request to the output.
// throughput: one request per cycle while the receiver takes words; an end request
// holds the input side while its twelve further words go out on the output port.
// the output word sits in a register, so up to two more requests are taken
// while the receiver stalls; after that tready drops until words move on.
// reset closes the window, clears all statistics and sets the window length
// to 1024.
`default_nettype none

module vibration_window_statistics_core #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,

  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [vws_pkg::LEN_BITS-1:0]        cfg_data_i,

  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // accel_x, accel_y, accel_z, sample_good, sample_clipped, source_fault, time_ms
  input  wire  [((3*SAMPLE_BITS+35+7)/8)*8-1:0] s_axis_tdata,
  // req_type
  input  wire  [7:0]                          s_axis_tuser,

  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // stat_value
  output logic [vws_pkg::VALUE_BITS-1:0]      m_axis_tdata,
  // status, stat_index
  output logic [7:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int unsigned S    = SAMPLE_BITS;
  localparam int unsigned SQ_W = 2 * SAMPLE_BITS;
  localparam int unsigned TB   = vws_pkg::TIME_BITS;

  vws_pkg::item_ctl_t in_ctl;
  vws_pkg::item_ctl_t st_ctl;
  vws_pkg::ack_t      ack;
  vws_pkg::emit_req_t emit_req;

  logic [S-1:0]                   mag_x, mag_y, mag_z;
  logic [SQ_W-1:0]                sq_x, sq_y, sq_z;
  logic                           take;
  logic [vws_pkg::VALUE_BITS-1:0] sel_value;
  logic [1:0]                     out_status;
  logic [vws_pkg::INDEX_BITS-1:0] out_index;

  assign cfg_ready_o = 1'b1;

  assign in_ctl.valid   = s_axis_tvalid;
  assign in_ctl.req     = s_axis_tuser[1:0];
  assign in_ctl.good    = s_axis_tdata[3*S];
  assign in_ctl.clipped = s_axis_tdata[3*S+1];
  assign in_ctl.fault   = s_axis_tdata[3*S+2];
  assign in_ctl.time_ms = s_axis_tdata[3*S+3 +: TB];

  vws_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_ctl_i   (in_ctl),
    .accel_x_i  (s_axis_tdata[0 +: S]),
    .accel_y_i  (s_axis_tdata[S +: S]),
    .accel_z_i  (s_axis_tdata[2*S +: S]),
    .take_i     (take),
    .ctl_o      (st_ctl),
    .mag_x_o    (mag_x),
    .mag_y_o    (mag_y),
    .mag_z_o    (mag_z),
    .sq_x_o     (sq_x),
    .sq_y_o     (sq_y),
    .sq_z_o     (sq_z)
  );

  vws_stats #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (st_ctl),
    .mag_x_i     (mag_x),
    .mag_y_i     (mag_y),
    .mag_z_i     (mag_z),
    .sq_x_i      (sq_x),
    .sq_y_i      (sq_y),
    .sq_z_i      (sq_z),
    .emit_i      (emit_req),
    .take_o      (take),
    .ack_o       (ack),
    .sel_value_o (sel_value)
  );

  vws_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ack_i        (ack),
    .sel_value_i  (sel_value),
    .emit_o       (emit_req),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_index_o  (out_index),
    .out_value_o  (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tuser = {2'b00, out_index, out_status};

endmodule

`default_nettype wire

// ===== design/vws_front.sv =====
// input register and squaring stage
`default_nettype none

module vws_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  vws_pkg::item_ctl_t       in_ctl_i,
  input  wire  [SAMPLE_BITS-1:0]   accel_x_i,
  input  wire  [SAMPLE_BITS-1:0]   accel_y_i,
  input  wire  [SAMPLE_BITS-1:0]   accel_z_i,
  input  wire                      take_i,
  output vws_pkg::item_ctl_t       ctl_o,
  output logic [SAMPLE_BITS-1:0]   mag_x_o,
  output logic [SAMPLE_BITS-1:0]   mag_y_o,
  output logic [SAMPLE_BITS-1:0]   mag_z_o,
  output logic [2*SAMPLE_BITS-1:0] sq_x_o,
  output logic [2*SAMPLE_BITS-1:0] sq_y_o,
  output logic [2*SAMPLE_BITS-1:0] sq_z_o
);

  localparam int unsigned SQ_W = 2 * SAMPLE_BITS;

  vws_pkg::item_ctl_t   in_ctl;
  vws_pkg::item_ctl_t   s1_ctl_q;
  vws_pkg::item_ctl_t   s2_ctl_q;
  logic [SAMPLE_BITS-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic [SAMPLE_BITS-1:0] mag_x, mag_y, mag_z;
  logic [SAMPLE_BITS-1:0] s2_mx_q, s2_my_q, s2_mz_q;
  logic [SQ_W-1:0]        s2_sx_q, s2_sy_q, s2_sz_q;
  logic                   s2_free;
  logic                   s1_free;

  function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] raw);
    magnitude = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
  endfunction

  assign mag_x = magnitude(s1_x_q);
  assign mag_y = magnitude(s1_y_q);
  assign mag_z = magnitude(s1_z_q);

  always_comb begin
    in_ctl       = in_ctl_i;
    in_ctl.valid = in_valid_i;
  end

  assign s2_free    = !s2_ctl_q.valid || take_i;
  assign s1_free    = !s1_ctl_q.valid || s2_free;
  assign in_ready_o = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
    end else begin
      if (s1_free) begin
        s1_ctl_q <= in_ctl;
      end
      if (s2_free) begin
        s2_ctl_q <= s1_ctl_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_x_q <= accel_x_i;
      s1_y_q <= accel_y_i;
      s1_z_q <= accel_z_i;
    end
    if (s2_free && s1_ctl_q.valid) begin
      s2_mx_q <= mag_x;
      s2_my_q <= mag_y;
      s2_mz_q <= mag_z;
      s2_sx_q <= SQ_W'(mag_x) * SQ_W'(mag_x);
      s2_sy_q <= SQ_W'(mag_y) * SQ_W'(mag_y);
      s2_sz_q <= SQ_W'(mag_z) * SQ_W'(mag_z);
    end
  end

  assign ctl_o   = s2_ctl_q;
  assign mag_x_o = s2_mx_q;
  assign mag_y_o = s2_my_q;
  assign mag_z_o = s2_mz_q;
  assign sq_x_o  = s2_sx_q;
  assign sq_y_o  = s2_sy_q;
  assign sq_z_o  = s2_sz_q;

endmodule

`default_nettype wire

// ===== design/vws_stats.sv =====
// window state, accumulation with overflow check and statistic word select
`default_nettype none

module vws_stats #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_valid_i,
  input  wire  [vws_pkg::LEN_BITS-1:0]         cfg_data_i,
  input  vws_pkg::item_ctl_t                   ctl_i,
  input  wire  [SAMPLE_BITS-1:0]               mag_x_i,
  input  wire  [SAMPLE_BITS-1:0]               mag_y_i,
  input  wire  [SAMPLE_BITS-1:0]               mag_z_i,
  input  wire  [2*SAMPLE_BITS-1:0]             sq_x_i,
  input  wire  [2*SAMPLE_BITS-1:0]             sq_y_i,
  input  wire  [2*SAMPLE_BITS-1:0]             sq_z_i,
  input  vws_pkg::emit_req_t                   emit_i,
  output logic                                 take_o,
  output vws_pkg::ack_t                        ack_o,
  output logic [vws_pkg::VALUE_BITS-1:0]       sel_value_o
);

  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS;
  localparam int unsigned VW    = vws_pkg::VALUE_BITS;
  localparam int unsigned CMP_W = (COUNT_BITS > vws_pkg::LEN_BITS) ? COUNT_BITS
                                                                   : vws_pkg::LEN_BITS;

  logic [vws_pkg::LEN_BITS-1:0]  window_length_q;
  logic [vws_pkg::LEN_BITS-1:0]  latched_q, latched_d;
  logic                          open_q, open_d;
  logic [VW-1:0]                 sum_x_q, sum_y_q, sum_z_q, sum_v_q;
  logic [VW-1:0]                 sum_x_d, sum_y_d, sum_z_d, sum_v_d;
  logic [SAMPLE_BITS-1:0]        peak_x_q, peak_y_q, peak_z_q;
  logic [SAMPLE_BITS-1:0]        peak_x_d, peak_y_d, peak_z_d;
  logic [SQ_W-1:0]               peak_v_q, peak_v_d;
  logic [COUNT_BITS-1:0]         acq_q, acq_d;
  logic [COUNT_BITS-1:0]         valid_cnt_q, valid_cnt_d;
  logic [vws_pkg::TIME_BITS-1:0] start_q, start_d;
  logic [vws_pkg::FLAG_BITS-1:0] flags_q, flags_d;

  logic            fire;
  logic [SQ_W-1:0] vec;
  logic [VW:0]     add_x, add_y, add_z, add_v;
  logic            ok_x, ok_y, ok_z, ok_v;
  logic            full;
  logic            complete;

  assign fire   = ctl_i.valid && emit_i.ready;
  assign take_o = fire;

  // three squares of SAMPLE_BITS magnitudes never carry out of SQ_W bits
  assign vec = sq_x_i + sq_y_i + sq_z_i;

  assign add_x = {1'b0, sum_x_q} + (VW + 1)'(sq_x_i);
  assign add_y = {1'b0, sum_y_q} + (VW + 1)'(sq_y_i);
  assign add_z = {1'b0, sum_z_q} + (VW + 1)'(sq_z_i);
  assign add_v = {1'b0, sum_v_q} + (VW + 1)'(vec);
  assign ok_x  = !add_x[VW];
  assign ok_y  = ok_x && !add_y[VW];
  assign ok_z  = ok_y && !add_z[VW];
  assign ok_v  = ok_z && !add_v[VW];

  assign full     = (CMP_W'(acq_q) >= CMP_W'(latched_q)) || (&acq_q);
  assign complete = !flags_q[vws_pkg::FLAG_SRC_ERROR]
                    && (CMP_W'(acq_q) == CMP_W'(latched_q));

  always_comb begin
    open_d      = open_q;
    latched_d   = latched_q;
    sum_x_d     = sum_x_q;
    sum_y_d     = sum_y_q;
    sum_z_d     = sum_z_q;
    sum_v_d     = sum_v_q;
    peak_x_d    = peak_x_q;
    peak_y_d    = peak_y_q;
    peak_z_d    = peak_z_q;
    peak_v_d    = peak_v_q;
    acq_d       = acq_q;
    valid_cnt_d = valid_cnt_q;
    start_d     = start_q;
    flags_d     = flags_q;

    ack_o          = '0;
    ack_o.valid    = fire;
    ack_o.status   = vws_pkg::STATUS_OK;
    ack_o.end_time = ctl_i.time_ms;

    case (ctl_i.req)
      vws_pkg::REQ_BEGIN: begin
        if (open_q) begin
          ack_o.status = vws_pkg::STATUS_INVALID;
        end else if (ctl_i.fault) begin
          ack_o.status = vws_pkg::STATUS_FAULT;
        end else begin
          open_d      = 1'b1;
          latched_d   = window_length_q;
          sum_x_d     = '0;
          sum_y_d     = '0;
          sum_z_d     = '0;
          sum_v_d     = '0;
          peak_x_d    = '0;
          peak_y_d    = '0;
          peak_z_d    = '0;
          peak_v_d    = '0;
          acq_d       = '0;
          valid_cnt_d = '0;
          start_d     = ctl_i.time_ms;
          flags_d     = '0;
        end
      end
      vws_pkg::REQ_SAMPLE: begin
        if (!open_q || full) begin
          ack_o.status = vws_pkg::STATUS_INVALID;
        end else if (ctl_i.fault) begin
          ack_o.status = vws_pkg::STATUS_FAULT;
          flags_d[vws_pkg::FLAG_SRC_ERROR] = 1'b1;
        end else begin
          acq_d = acq_q + 1'b1;
          if (ctl_i.good) begin
            valid_cnt_d = valid_cnt_q + 1'b1;
            if (!flags_q[vws_pkg::FLAG_OVERFLOW]) begin
              if (ok_x) sum_x_d = add_x[VW-1:0];
              if (ok_y) sum_y_d = add_y[VW-1:0];
              if (ok_z) sum_z_d = add_z[VW-1:0];
              if (ok_v) begin
                sum_v_d = add_v[VW-1:0];
                if (mag_x_i > peak_x_q) peak_x_d = mag_x_i;
                if (mag_y_i > peak_y_q) peak_y_d = mag_y_i;
                if (mag_z_i > peak_z_q) peak_z_d = mag_z_i;
                if (vec > peak_v_q)     peak_v_d = vec;
              end else begin
                flags_d[vws_pkg::FLAG_OVERFLOW] = 1'b1;
              end
            end
          end
          if (ctl_i.clipped) begin
            flags_d[vws_pkg::FLAG_SATURATION] = 1'b1;
          end
        end
      end
      vws_pkg::REQ_END: begin
        if (!open_q) begin
          ack_o.status = vws_pkg::STATUS_INVALID;
        end else begin
          open_d      = 1'b0;
          ack_o.burst = 1'b1;
          if (ctl_i.fault) begin
            ack_o.status = vws_pkg::STATUS_FAULT;
            flags_d[vws_pkg::FLAG_SRC_ERROR] = 1'b1;
          end
        end
      end
      default: begin
        ack_o.status = vws_pkg::STATUS_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= vws_pkg::WINDOW_LENGTH_RESET;
      latched_q       <= '0;
      open_q          <= 1'b0;
      sum_x_q         <= '0;
      sum_y_q         <= '0;
      sum_z_q         <= '0;
      sum_v_q         <= '0;
      peak_x_q        <= '0;
      peak_y_q        <= '0;
      peak_z_q        <= '0;
      peak_v_q        <= '0;
      acq_q           <= '0;
      valid_cnt_q     <= '0;
      start_q         <= '0;
      flags_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        window_length_q <= cfg_data_i;
      end
      if (fire) begin
        latched_q   <= latched_d;
        open_q      <= open_d;
        sum_x_q     <= sum_x_d;
        sum_y_q     <= sum_y_d;
        sum_z_q     <= sum_z_d;
        sum_v_q     <= sum_v_d;
        peak_x_q    <= peak_x_d;
        peak_y_q    <= peak_y_d;
        peak_z_q    <= peak_z_d;
        peak_v_q    <= peak_v_d;
        acq_q       <= acq_d;
        valid_cnt_q <= valid_cnt_d;
        start_q     <= start_d;
        flags_q     <= flags_d;
      end
    end
  end

  always_comb begin
    case (emit_i.sel)
      vws_pkg::IDX_SUM_X:  sel_value_o = sum_x_q;
      vws_pkg::IDX_SUM_Y:  sel_value_o = sum_y_q;
      vws_pkg::IDX_SUM_Z:  sel_value_o = sum_z_q;
      vws_pkg::IDX_SUM_V:  sel_value_o = sum_v_q;
      vws_pkg::IDX_PEAK_X: sel_value_o = VW'(peak_x_q);
      vws_pkg::IDX_PEAK_Y: sel_value_o = VW'(peak_y_q);
      vws_pkg::IDX_PEAK_Z: sel_value_o = VW'(peak_z_q);
      vws_pkg::IDX_PEAK_V: sel_value_o = VW'(peak_v_q);
      vws_pkg::IDX_ACQ:    sel_value_o = VW'(acq_q);
      vws_pkg::IDX_VALID:  sel_value_o = VW'(valid_cnt_q);
      vws_pkg::IDX_START:  sel_value_o = VW'(start_q);
      vws_pkg::IDX_FLAGS:  sel_value_o = VW'({flags_q, complete});
      default:             sel_value_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/vws_emit.sv =====
// output word register and end-of-window word sequencer
`default_nettype none

module vws_emit (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  vws_pkg::ack_t                         ack_i,
  input  wire  [vws_pkg::VALUE_BITS-1:0]        sel_value_i,
  output vws_pkg::emit_req_t                    emit_o,
  input  wire                                   out_ready_i,
  output logic                                  out_valid_o,
  output logic [1:0]                            out_status_o,
  output logic [vws_pkg::INDEX_BITS-1:0]        out_index_o,
  output logic [vws_pkg::VALUE_BITS-1:0]        out_value_o,
  output logic                                  out_last_o
);

  localparam int unsigned VW = vws_pkg::VALUE_BITS;

  logic                             out_valid_q;
  logic [1:0]                       status_q;
  logic [vws_pkg::INDEX_BITS-1:0]   index_q;
  logic [VW-1:0]                    value_q;
  logic                             last_q;
  logic                             burst_q;
  logic [vws_pkg::INDEX_BITS-1:0]   next_q;
  logic [1:0]                       hold_status_q;
  logic [vws_pkg::TIME_BITS-1:0]    end_time_q;
  logic                             load;

  assign load         = !out_valid_q || out_ready_i;
  assign emit_o.ready = load && !burst_q;
  assign emit_o.sel   = burst_q ? next_q : vws_pkg::IDX_SUM_X;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      burst_q     <= 1'b0;
      next_q      <= vws_pkg::IDX_SUM_X;
    end else if (load) begin
      if (burst_q) begin
        out_valid_q <= 1'b1;
        next_q      <= next_q + 1'b1;
        if (next_q == vws_pkg::IDX_FLAGS) begin
          burst_q <= 1'b0;
        end
      end else if (ack_i.valid) begin
        out_valid_q <= 1'b1;
        if (ack_i.burst) begin
          burst_q <= 1'b1;
          next_q  <= vws_pkg::IDX_SUM_Y;
        end
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (burst_q) begin
        status_q <= hold_status_q;
        index_q  <= next_q;
        value_q  <= (next_q == vws_pkg::IDX_END) ? VW'(end_time_q) : sel_value_i;
        last_q   <= (next_q == vws_pkg::IDX_FLAGS);
      end else if (ack_i.valid) begin
        status_q <= ack_i.status;
        index_q  <= vws_pkg::IDX_SUM_X;
        if (ack_i.burst) begin
          value_q       <= sel_value_i;
          last_q        <= 1'b0;
          hold_status_q <= ack_i.status;
          end_time_q    <= ack_i.end_time;
        end else begin
          value_q <= '0;
          last_q  <= 1'b1;
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_index_o  = index_q;
  assign out_value_o  = value_q;
  assign out_last_o   = last_q;

endmodule

`default_nettype wire
